// ----- rtl/core/bswi_pkg.sv -----
// Shared types and constants of the bounded stack with bottom increment.
package bswi_pkg;

	localparam int WORD_W = 32;
	localparam int CNT_W  = 11;
	localparam int CMD_W  = 2;

	localparam logic [CMD_W-1:0] OP_PUSH = 2'd0;
	localparam logic [CMD_W-1:0] OP_POP  = 2'd1;
	localparam logic [CMD_W-1:0] OP_INCR = 2'd2;

	localparam logic [CNT_W-1:0]  MAX_SIZE_RESET = 11'd1024;
	localparam logic [WORD_W-1:0] EMPTY_WORD     = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [CMD_W-1:0]         command;
		logic signed [WORD_W-1:0] value;
		logic [CNT_W-1:0]         count;
	} in_item_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] popped_value;
		logic                     was_empty;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP,
		ST_INC
	} state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic push_en;
		logic pop_start;
		logic incr_start;
		logic incr_step;
		logic out_load;
	} cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic incr_any;
		logic incr_last;
	} sts_t;

endpackage

// ----- rtl/core/bounded_stack_with_increment.sv -----
// A push writes the RAM as it is accepted; a pop reads the top entry, then loads the output register
// once it is free. Increment walks n = min(count, fill depth) entries from the bottom, with one
// read-modify-write of the simple dual-port stack RAM per cycle.
// One item is in work at a time; a finished item waits in the output register meanwhile.
// Reset clears the fill depth and sets max_size to 1024; stack RAM contents stay
// undefined and need no clearing pass, since only pushed entries are ever read.
module bounded_stack_with_increment #(
	parameter int STACK_DEPTH = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [bswi_pkg::CNT_W-1:0] cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  bswi_pkg::in_item_t         in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output bswi_pkg::out_item_t        out_data
);

	// command and status buses between the sequencer and the datapath
	bswi_pkg::cmd_t cmd;
	bswi_pkg::sts_t sts;

	// Sequencer: accept items in idle, hold a popped word for the output
	// register, and advance the increment walk one entry per cycle.
	bswi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (in_data.command),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: a full stack or unused command code drops the item silently;
	// an empty pop returns all ones with the empty flag set.
	bswi_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.out_data  (out_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ----- rtl/core/bswi_ram.sv -----
// Generic simple dual-port RAM with registered, enabled read.
module bswi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/bswi_ctrl.sv -----
// Controller state machine: input/output handshake and command sequencing.
module bswi_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [bswi_pkg::CMD_W-1:0] command,
	output logic                      out_valid,
	input  logic                      out_stall,
	input  bswi_pkg::sts_t            sts,
	output bswi_pkg::cmd_t            cmd
);

	bswi_pkg::state_t state_q, state_d;
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bswi_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			bswi_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					unique case (command)
						bswi_pkg::OP_PUSH: begin
							cmd.push_en = 1'b1;
						end
						bswi_pkg::OP_POP: begin
							cmd.pop_start = 1'b1;
							state_d       = bswi_pkg::ST_POP;
						end
						bswi_pkg::OP_INCR: begin
							cmd.incr_start = 1'b1;
							if (sts.incr_any) begin
								state_d = bswi_pkg::ST_INC;
							end
						end
						default: begin
						end
					endcase
				end
			end
			bswi_pkg::ST_POP: begin
				// hold the read data until the output register frees up
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = bswi_pkg::ST_IDLE;
				end
			end
			bswi_pkg::ST_INC: begin
				cmd.incr_step = 1'b1;
				if (sts.incr_last) begin
					state_d = bswi_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bswi_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/core/bswi_dp.sv -----
// Datapath: stack memory, fill depth, increment walker and output register.
module bswi_dp #(
	parameter int STACK_DEPTH = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [bswi_pkg::CNT_W-1:0] cfg_wdata,
	input  bswi_pkg::in_item_t         in_data,
	output bswi_pkg::out_item_t        out_data,
	input  bswi_pkg::cmd_t             cmd,
	output bswi_pkg::sts_t             sts
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam int CW = (DW > bswi_pkg::CNT_W) ? DW : bswi_pkg::CNT_W;

	logic [bswi_pkg::CNT_W-1:0]  max_size_q;
	logic [DW-1:0]               fill_q;
	logic [DW-1:0]               lim_q;
	logic [AW-1:0]               idx_q;
	logic [bswi_pkg::WORD_W-1:0] incr_q;
	logic                        empty_q;
	bswi_pkg::out_item_t         out_q;

	logic                        can_push;
	logic                        is_empty;
	logic [DW-1:0]               lim_d;
	logic [DW-1:0]               fill_dec;
	logic [DW-1:0]               idx_next;

	logic                        ram_we;
	logic [AW-1:0]               ram_waddr;
	logic [bswi_pkg::WORD_W-1:0] ram_wdata;
	logic                        ram_re;
	logic [AW-1:0]               ram_raddr;
	logic [bswi_pkg::WORD_W-1:0] ram_rdata;

	assign is_empty = (fill_q == '0);
	assign can_push = (CW'(fill_q) < CW'(max_size_q)) && (CW'(fill_q) < CW'(STACK_DEPTH));
	assign lim_d    = (CW'(in_data.count) < CW'(fill_q)) ? DW'(in_data.count) : fill_q;
	assign fill_dec = fill_q - DW'(1);
	assign idx_next = DW'(idx_q) + DW'(1);

	assign sts.incr_any  = (lim_d != '0);
	assign sts.incr_last = (idx_next == lim_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = fill_q[AW-1:0];
		ram_wdata = in_data.value;
		ram_re    = 1'b0;
		ram_raddr = '0;
		if (cmd.push_en && can_push) begin
			ram_we = 1'b1;
		end
		if (cmd.incr_step) begin
			ram_we    = 1'b1;
			ram_waddr = idx_q;
			ram_wdata = ram_rdata + incr_q;
			if (!sts.incr_last) begin
				ram_re    = 1'b1;
				ram_raddr = idx_next[AW-1:0];
			end
		end
		if (cmd.pop_start && !is_empty) begin
			ram_re    = 1'b1;
			ram_raddr = fill_dec[AW-1:0];
		end
		if (cmd.incr_start && sts.incr_any) begin
			ram_re = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_size_q <= bswi_pkg::MAX_SIZE_RESET;
			fill_q     <= '0;
		end else begin
			if (cfg_we) begin
				max_size_q <= cfg_wdata;
			end
			if (cmd.push_en && can_push) begin
				fill_q <= fill_q + DW'(1);
			end else if (cmd.pop_start && !is_empty) begin
				fill_q <= fill_dec;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop_start) begin
			empty_q <= is_empty;
		end
		if (cmd.incr_start) begin
			incr_q <= in_data.value;
			lim_q  <= lim_d;
			idx_q  <= '0;
		end else if (cmd.incr_step) begin
			idx_q <= idx_next[AW-1:0];
		end
		if (cmd.out_load) begin
			out_q.popped_value <= empty_q ? bswi_pkg::EMPTY_WORD : ram_rdata;
			out_q.was_empty    <= empty_q;
		end
	end

	assign out_data = out_q;

	bswi_ram #(
		.WIDTH (bswi_pkg::WORD_W),
		.DEPTH (STACK_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

// ----- rtl/core/bswi_checker.sv -----
// Port-level checker for the bounded stack, bound to the top level.
module bswi_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       cfg_we,
	input logic [bswi_pkg::CNT_W-1:0] cfg_wdata,
	input logic                       in_valid,
	input logic                       in_stall,
	input bswi_pkg::in_item_t         in_data,
	input logic                       out_valid,
	input logic                       out_stall,
	input bswi_pkg::out_item_t        out_data
);

	logic pop_acc;
	assign pop_acc = in_valid && !in_stall && (in_data.command == bswi_pkg::OP_POP);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data))
		else $error("output item changed while stalled");

	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.was_empty |-> out_data.popped_value == bswi_pkg::EMPTY_WORD)
		else $error("empty pop did not return all ones");

	a_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pop_acc |=> in_stall)
		else $error("input not stalled while pop in work");

	a_pop_result: assert property (@(posedge clk) disable iff (!arst_n)
		pop_acc && !out_valid |-> ##2 out_valid)
		else $error("pop item not delivered on time");

endmodule

bind bounded_stack_with_increment bswi_checker u_bswi_checker (.*);
